>>> hdl/bpc_pkg.sv
// package with constants, types and helpers for the button press classifier
package bpc_pkg;

    // width of the elapsed tick counters
    localparam int COUNT_WIDTH = 16;
    // width of every configuration register
    localparam int CFG_WIDTH   = 16;
    // width of the configuration register index
    localparam int IDX_WIDTH   = 3;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_t;
    typedef logic [IDX_WIDTH-1:0]   cfg_idx_t;

    // configuration register indexes
    localparam cfg_idx_t REG_DEBOUNCE_TICKS   = 3'd0;
    localparam cfg_idx_t REG_SHORT_LIMIT      = 3'd1;
    localparam cfg_idx_t REG_LONG_HOLD        = 3'd2;
    localparam cfg_idx_t REG_SLOW_HALF_PERIOD = 3'd3;
    localparam cfg_idx_t REG_FAST_HALF_PERIOD = 3'd4;

    // configuration reset values
    localparam cfg_t DEBOUNCE_TICKS_RST   = 16'd15;
    localparam cfg_t SHORT_LIMIT_RST      = 16'd1000;
    localparam cfg_t LONG_HOLD_RST        = 16'd3000;
    localparam cfg_t SLOW_HALF_PERIOD_RST = 16'd500;
    localparam cfg_t FAST_HALF_PERIOD_RST = 16'd100;

    // largest value of an elapsed counter
    localparam count_t COUNT_MAX = '1;

    // button levels
    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    // led mode codes; the fourth code is unused and behaves as off
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_SLOW = 2'd1,
        MODE_FAST = 2'd2
    } mode_t;

    // saturating increment of an elapsed counter
    function automatic count_t sat_inc(input count_t c);
        sat_inc = (c == COUNT_MAX) ? COUNT_MAX : count_t'(c + 1'b1);
    endfunction

endpackage

>>> hdl/button_press_classifier_led_mode_unit.sv
// button debouncer, short and long press classifier and led blink mode selector
// the result of an accepted tick transaction is registered and reaches the m_ side in the next cycle
// throughput: one tick transaction per cycle while the m_ side is not stalled; the per-tick update is a single
// combinational pass between the state registers and the result register
// reset: configuration returns to its defaults, levels to released, counters,
// mode and leds to zero, and the result register is emptied
module button_press_classifier_led_mode_unit
    import bpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write port
    input  logic       cfg_wr_en,
    input  cfg_idx_t   cfg_index,
    input  cfg_t       cfg_data,
    // tick input channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_raw_level,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_mode,
    output logic       m_led_one,
    output logic       m_led_two,
    output logic       m_stable_level,
    output logic       m_press_event,
    output logic       m_short_event,
    output logic       m_release_event,
    output logic       m_long_event
);

    // configuration registers
    cfg_t debounce_ticks_reg;
    cfg_t short_limit_reg;
    cfg_t long_hold_reg;
    cfg_t slow_half_period_reg;
    cfg_t fast_half_period_reg;

    // tick state
    logic   sampled_level_reg, sampled_level_next;
    logic   settling_reg,      settling_next;
    count_t settle_count_reg,  settle_count_next;
    logic   stable_now_reg,    stable_now_next;
    count_t hold_count_reg,    hold_count_next;
    logic   long_armed_reg,    long_armed_next;
    mode_t  mode_reg,          mode_next;
    logic   led_one_reg,       led_one_next;
    logic   led_two_reg,       led_two_next;
    count_t slow_count_reg,    slow_count_next;
    count_t fast_count_reg,    fast_count_next;

    // event flags of the current tick
    logic press_next;
    logic short_next;
    logic release_next;
    logic long_next;

    // result register
    logic       m_valid_reg;
    logic [1:0] m_mode_reg;
    logic       m_led_one_reg;
    logic       m_led_two_reg;
    logic       m_stable_level_reg;
    logic       m_press_event_reg;
    logic       m_short_event_reg;
    logic       m_release_event_reg;
    logic       m_long_event_reg;

    logic accept;

    // accept while the result register is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg   <= DEBOUNCE_TICKS_RST;
            short_limit_reg      <= SHORT_LIMIT_RST;
            long_hold_reg        <= LONG_HOLD_RST;
            slow_half_period_reg <= SLOW_HALF_PERIOD_RST;
            fast_half_period_reg <= FAST_HALF_PERIOD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg_data;
                REG_SHORT_LIMIT:      short_limit_reg      <= cfg_data;
                REG_LONG_HOLD:        long_hold_reg        <= cfg_data;
                REG_SLOW_HALF_PERIOD: slow_half_period_reg <= cfg_data;
                REG_FAST_HALF_PERIOD: fast_half_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-tick update: counters, debounce, edges, long hold, leds
    always_comb begin
        // elapsed counters advance first
        settle_count_next  = sat_inc(settle_count_reg);
        hold_count_next    = sat_inc(hold_count_reg);
        slow_count_next    = sat_inc(slow_count_reg);
        fast_count_next    = sat_inc(fast_count_reg);
        sampled_level_next = sampled_level_reg;
        settling_next      = settling_reg;
        stable_now_next    = stable_now_reg;
        long_armed_next    = long_armed_reg;
        mode_next          = mode_reg;
        led_one_next       = led_one_reg;
        led_two_next       = led_two_reg;
        press_next         = 1'b0;
        short_next         = 1'b0;
        release_next       = 1'b0;
        long_next          = 1'b0;

        // raw change restarts the settle time
        if (s_raw_level != sampled_level_reg) begin
            sampled_level_next = s_raw_level;
            settling_next      = 1'b1;
            settle_count_next  = '0;
        end
        if (settling_next && (settle_count_next >= debounce_ticks_reg)) begin
            stable_now_next = sampled_level_next;
            settling_next   = 1'b0;
        end

        // edges of the debounced level
        if (stable_now_next != stable_now_reg) begin
            long_armed_next = 1'b1;
            if (stable_now_next == LEVEL_PRESSED) begin
                press_next      = 1'b1;
                hold_count_next = '0;
                case (mode_reg)
                    MODE_OFF:  mode_next = MODE_SLOW;
                    MODE_SLOW: mode_next = MODE_FAST;
                    default:   mode_next = MODE_OFF;
                endcase
            end else begin
                short_next      = (hold_count_next <= short_limit_reg);
                release_next    = 1'b1;
                long_armed_next = 1'b0;
            end
        end

        // single long pulse per press
        if (long_armed_next && (hold_count_next >= long_hold_reg)) begin
            long_next       = 1'b1;
            long_armed_next = 1'b0;
        end

        // blink the led of the current mode, off forces both low
        case (mode_next)
            MODE_SLOW: begin
                if (slow_count_next >= slow_half_period_reg) begin
                    led_one_next    = !led_one_reg;
                    slow_count_next = '0;
                end
            end
            MODE_FAST: begin
                if (fast_count_next >= fast_half_period_reg) begin
                    led_two_next    = !led_two_reg;
                    fast_count_next = '0;
                end
            end
            default: begin
                led_one_next = 1'b0;
                led_two_next = 1'b0;
            end
        endcase
    end

    // tick state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sampled_level_reg <= LEVEL_RELEASED;
            settling_reg      <= 1'b0;
            settle_count_reg  <= '0;
            stable_now_reg    <= LEVEL_RELEASED;
            hold_count_reg    <= '0;
            long_armed_reg    <= 1'b0;
            mode_reg          <= MODE_OFF;
            led_one_reg       <= 1'b0;
            led_two_reg       <= 1'b0;
            slow_count_reg    <= '0;
            fast_count_reg    <= '0;
        end else if (accept) begin
            sampled_level_reg <= sampled_level_next;
            settling_reg      <= settling_next;
            settle_count_reg  <= settle_count_next;
            stable_now_reg    <= stable_now_next;
            hold_count_reg    <= hold_count_next;
            long_armed_reg    <= long_armed_next;
            mode_reg          <= mode_next;
            led_one_reg       <= led_one_next;
            led_two_reg       <= led_two_next;
            slow_count_reg    <= slow_count_next;
            fast_count_reg    <= fast_count_next;
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_mode_reg          <= mode_next;
            m_led_one_reg       <= led_one_next;
            m_led_two_reg       <= led_two_next;
            m_stable_level_reg  <= stable_now_next;
            m_press_event_reg   <= press_next;
            m_short_event_reg   <= short_next;
            m_release_event_reg <= release_next;
            m_long_event_reg    <= long_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_mode          = m_mode_reg;
    assign m_led_one       = m_led_one_reg;
    assign m_led_two       = m_led_two_reg;
    assign m_stable_level  = m_stable_level_reg;
    assign m_press_event   = m_press_event_reg;
    assign m_short_event   = m_short_event_reg;
    assign m_release_event = m_release_event_reg;
    assign m_long_event    = m_long_event_reg;

endmodule

>>> bench/bpc_tick_checker.sv
// tick result checker: predicts every result of the button classifier and compares it
`timescale 1ns / 100ps

module bpc_tick_checker
    import bpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  cfg_idx_t   cfg_index,
    input  cfg_t       cfg_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_raw_level,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_mode,
    input  logic       m_led_one,
    input  logic       m_led_two,
    input  logic       m_stable_level,
    input  logic       m_press_event,
    input  logic       m_short_event,
    input  logic       m_release_event,
    input  logic       m_long_event,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [1:0] mode;
        logic       led_one;
        logic       led_two;
        logic       stable;
        logic       press_ev;
        logic       short_ev;
        logic       rel_ev;
        logic       long_ev;
    } tick_result_t;

    // shadow copy of the configuration registers
    cfg_t deb_ticks;
    cfg_t short_lim;
    cfg_t long_lim;
    cfg_t slow_half;
    cfg_t fast_half;

    // predicted block state
    logic       smp_lvl;
    logic       settling;
    logic       stb_now;
    logic       stb_prev;
    logic       long_armed;
    logic       led1;
    logic       led2;
    logic [1:0] mode_q;
    count_t     settle_cnt;
    count_t     hold_cnt;
    count_t     slow_cnt;
    count_t     fast_cnt;

    tick_result_t expected_ticks[$];

    // elapsed counters stop at their top value
    function automatic count_t elapse(input count_t c);
        return (c == COUNT_MAX) ? c : c + count_t'(1);
    endfunction

    // one millisecond tick: debounce, edge classification, mode and led update
    function tick_result_t classify_tick(input logic raw);
        tick_result_t r;
        r = '0;
        settle_cnt = elapse(settle_cnt);
        hold_cnt   = elapse(hold_cnt);
        slow_cnt   = elapse(slow_cnt);
        fast_cnt   = elapse(fast_cnt);

        // any raw change restarts the settle time
        if (raw != smp_lvl) begin
            smp_lvl    = raw;
            settling   = 1'b1;
            settle_cnt = '0;
        end
        if (settling && settle_cnt >= deb_ticks) begin
            stb_now  = smp_lvl;
            settling = 1'b0;
        end

        // debounced edges
        if (stb_now != stb_prev) begin
            long_armed = 1'b1;
            if (stb_now == LEVEL_PRESSED) begin
                r.press_ev = 1'b1;
                case (mode_q)
                    MODE_OFF:  mode_q = MODE_SLOW;
                    MODE_SLOW: mode_q = MODE_FAST;
                    default:   mode_q = MODE_OFF;
                endcase
                hold_cnt = '0;
            end else begin
                if (hold_cnt <= short_lim)
                    r.short_ev = 1'b1;
                r.rel_ev   = 1'b1;
                long_armed = 1'b0;
            end
            stb_prev = stb_now;
        end

        if (long_armed && hold_cnt >= long_lim) begin
            r.long_ev  = 1'b1;
            long_armed = 1'b0;
        end

        // blink the led of the current mode, off clears both
        if (mode_q == MODE_SLOW) begin
            if (slow_cnt >= slow_half) begin
                led1     = ~led1;
                slow_cnt = '0;
            end
        end else if (mode_q == MODE_FAST) begin
            if (fast_cnt >= fast_half) begin
                led2     = ~led2;
                fast_cnt = '0;
            end
        end else begin
            led1 = 1'b0;
            led2 = 1'b0;
        end

        r.mode    = mode_q;
        r.led_one = led1;
        r.led_two = led2;
        r.stable  = stb_now;
        return r;
    endfunction

    // watch both channels and the register port
    always @(posedge aclk) begin
        tick_result_t want;
        tick_result_t got;
        if (!aresetn) begin
            deb_ticks  = DEBOUNCE_TICKS_RST;
            short_lim  = SHORT_LIMIT_RST;
            long_lim   = LONG_HOLD_RST;
            slow_half  = SLOW_HALF_PERIOD_RST;
            fast_half  = FAST_HALF_PERIOD_RST;
            smp_lvl    = LEVEL_RELEASED;
            settling   = 1'b0;
            stb_now    = LEVEL_RELEASED;
            stb_prev   = LEVEL_RELEASED;
            long_armed = 1'b0;
            led1       = 1'b0;
            led2       = 1'b0;
            mode_q     = MODE_OFF;
            settle_cnt = '0;
            hold_cnt   = '0;
            slow_cnt   = '0;
            fast_cnt   = '0;
            fail_count = 0;
            expected_ticks.delete();
            pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DEBOUNCE_TICKS:   deb_ticks = cfg_data;
                    REG_SHORT_LIMIT:      short_lim = cfg_data;
                    REG_LONG_HOLD:        long_lim  = cfg_data;
                    REG_SLOW_HALF_PERIOD: slow_half = cfg_data;
                    REG_FAST_HALF_PERIOD: fast_half = cfg_data;
                    default: ;
                endcase
            end

            // push before pop so a same-edge result still matches the oldest tick
            if (s_valid && s_ready)
                expected_ticks.push_back(classify_tick(s_raw_level));

            if (m_valid && m_ready) begin
                got.mode     = m_mode;
                got.led_one  = m_led_one;
                got.led_two  = m_led_two;
                got.stable   = m_stable_level;
                got.press_ev = m_press_event;
                got.short_ev = m_short_event;
                got.rel_ev   = m_release_event;
                got.long_ev  = m_long_event;
                if (expected_ticks.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transaction at %0t", $realtime);
                    fail_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (want != got) begin
                        if (fail_count < 10) begin
                            $display("result mismatch at %0t: expected mode %0d leds %b%b stable %b press %b short %b release %b long %b",
                                     $realtime, want.mode, want.led_one, want.led_two,
                                     want.stable, want.press_ev, want.short_ev, want.rel_ev,
                                     want.long_ev);
                            $display("  got mode %0d leds %b%b stable %b press %b short %b release %b long %b",
                                     got.mode, got.led_one, got.led_two,
                                     got.stable, got.press_ev, got.short_ev, got.rel_ev,
                                     got.long_ev);
                        end
                        fail_count++;
                    end
                end
            end
            pending <= expected_ticks.size();
        end
    end

endmodule

>>> bench/tb_top.sv
// testbench top: clock, reset, tick stimulus, result stalls and the verdict
`timescale 1ns / 100ps

module tb_top;
    import bpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_AT    = 300;
    localparam int HOLD_OFF_LEN   = 150;
    localparam int PHASE_TICKS    = 190;
    localparam int HOLD_TICKS     = 120;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    cfg_idx_t   cfg_index;
    cfg_t       cfg_data;
    logic       s_valid;
    logic       s_ready;
    logic       s_raw_level;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_mode;
    logic       m_led_one;
    logic       m_led_two;
    logic       m_stable_level;
    logic       m_press_event;
    logic       m_short_event;
    logic       m_release_event;
    logic       m_long_event;

    int fail_count;
    int pending;
    int idle_cycles;
    bit no_idle;
    cfg_t cfg_now[5];

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    button_press_classifier_led_mode_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_raw_level     (s_raw_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mode          (m_mode),
        .m_led_one       (m_led_one),
        .m_led_two       (m_led_two),
        .m_stable_level  (m_stable_level),
        .m_press_event   (m_press_event),
        .m_short_event   (m_short_event),
        .m_release_event (m_release_event),
        .m_long_event    (m_long_event)
    );

    bpc_tick_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_raw_level     (s_raw_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mode          (m_mode),
        .m_led_one       (m_led_one),
        .m_led_two       (m_led_two),
        .m_stable_level  (m_stable_level),
        .m_press_event   (m_press_event),
        .m_short_event   (m_short_event),
        .m_release_event (m_release_event),
        .m_long_event    (m_long_event),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // offer one tick transaction after a random gap and wait for its acceptance
    task automatic send_tick(input logic lvl);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_raw_level <= lvl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (3) @(posedge aclk);
    endtask

    // one register write
    task automatic write_reg(input cfg_idx_t idx, input cfg_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    // write all five registers back to back
    task automatic load_settings(input cfg_t deb, input cfg_t shrt, input cfg_t hold,
                                 input cfg_t slow, input cfg_t fast);
        cfg_now = '{deb, shrt, hold, slow, fast};
        write_reg(REG_DEBOUNCE_TICKS, deb);
        write_reg(REG_SHORT_LIMIT, shrt);
        write_reg(REG_LONG_HOLD, hold);
        write_reg(REG_SLOW_HALF_PERIOD, slow);
        write_reg(REG_FAST_HALF_PERIOD, fast);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly bouncy press and release sequences, some pure noise
    task automatic run_phase(input int n_ticks);
        int   sent;
        int   len;
        int   span;
        logic lvl;
        sent = 0;
        lvl  = LEVEL_RELEASED;
        span = int'(cfg_now[0]) + int'(cfg_now[2]) + 6;
        if (span > 40)
            span = 40;
        while (sent < n_ticks) begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, 5);
                repeat (len) send_tick(logic'($urandom_range(0, 1)));
                sent += len;
            end else begin
                // contact bounce then a steady level
                len = $urandom_range(0, 3);
                repeat (len) send_tick(logic'($urandom_range(0, 1)));
                sent += len;
                lvl = ($urandom_range(0, 4) == 0) ? lvl : ~lvl;
                len = $urandom_range(1, span);
                repeat (len) send_tick(lvl);
                sent += len;
            end
        end
        no_idle = 1'b0;
    endtask

    // result side: random stalls and one long hold-off to back up the block
    initial begin
        int gap;
        int taken;
        bit held;
        m_ready = 1'b0;
        taken   = 0;
        held    = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 12);
            if (!held && taken == HOLD_OFF_AT) begin
                held = 1'b1;
                gap  = HOLD_OFF_LEN;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[button_press_classifier_led_mode_unit] ERROR");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_raw_level = LEVEL_RELEASED;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_DEBOUNCE_TICKS;
        cfg_data    = '0;
        no_idle     = 1'b0;
        cfg_now     = '{DEBOUNCE_TICKS_RST, SHORT_LIMIT_RST, LONG_HOLD_RST,
                        SLOW_HALF_PERIOD_RST, FAST_HALF_PERIOD_RST};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: a short glitch never reaches the stable level
        send_tick(LEVEL_PRESSED);
        send_tick(LEVEL_PRESSED);
        send_tick(LEVEL_PRESSED);
        send_tick(LEVEL_RELEASED);
        send_tick(LEVEL_RELEASED);
        drain();

        // all zero: same-tick debounce, long pulse on press, leds toggle every tick
        load_settings('0, '0, '0, '0, '0);
        send_tick(LEVEL_PRESSED);
        send_tick(LEVEL_PRESSED);
        send_tick(LEVEL_RELEASED);
        send_tick(LEVEL_PRESSED);
        send_tick(LEVEL_RELEASED);
        send_tick(LEVEL_PRESSED);
        send_tick(LEVEL_PRESSED);
        send_tick(LEVEL_RELEASED);
        send_tick(LEVEL_PRESSED);
        send_tick(LEVEL_RELEASED);
        send_tick(LEVEL_RELEASED);
        send_tick(LEVEL_PRESSED);
        send_tick(LEVEL_RELEASED);
        drain();

        // random sequences over several settings, extremes among them
        load_settings(16'd1, 16'd3, 16'd6, 16'd2, 16'd1);
        run_phase(PHASE_TICKS);
        drain();
        load_settings(16'd3, 16'd0, 16'd1, 16'd1, 16'd4);
        run_phase(PHASE_TICKS);
        drain();
        load_settings(16'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(PHASE_TICKS);
        drain();
        load_settings(16'hFFFF, 16'd10, 16'd20, 16'd3, 16'd2);
        run_phase(PHASE_TICKS);
        drain();
        repeat (2) begin
            load_settings(cfg_t'($urandom_range(1, 6)), cfg_t'($urandom_range(0, 20)),
                          cfg_t'($urandom_range(1, 30)), cfg_t'($urandom_range(1, 8)),
                          cfg_t'($urandom_range(1, 8)));
            run_phase(PHASE_TICKS);
            drain();
        end

        // one press held well past the long hold, then released
        load_settings(16'd1, 16'd40, 16'd80, 16'd9, 16'd1);
        no_idle = 1'b1;
        repeat (4) send_tick(LEVEL_RELEASED);
        repeat (HOLD_TICKS) send_tick(LEVEL_PRESSED);
        repeat (4) send_tick(LEVEL_RELEASED);
        no_idle = 1'b0;
        drain();

        if (fail_count == 0 && pending == 0)
            $display("[button_press_classifier_led_mode_unit] OK");
        else
            $display("[button_press_classifier_led_mode_unit] ERROR");
        $finish;
    end

endmodule
